/* design/bicubic_bezier_patch_eval_defines.svh */
// assertion macros for the bicubic bezier patch evaluator
`ifndef BICUBIC_BEZIER_PATCH_EVAL_DEFINES_SVH
`define BICUBIC_BEZIER_PATCH_EVAL_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BBPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbpe: same-cycle check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BBPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbpe: next-cycle check failed");

`endif

/* design/bbpe_pkg.sv */
// types, codes and constants of the bicubic bezier patch evaluator
`default_nettype none

package bbpe_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RUN,
    ST_DRAIN
  } bbpe_state_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SHIFT,
    OP_END_L1,
    OP_END_L2,
    OP_END_CURVE
  } bbpe_op_e;

  localparam logic OperLoad = 1'b0;
  localparam logic OperEval = 1'b1;

  localparam int unsigned TWidth   = 17;
  localparam int unsigned FracBits = 16;
  localparam logic [TWidth-1:0] TOne = 17'h10000;

  localparam logic [1:0] LastCoord    = 2'd2;
  localparam logic [1:0] LastCol      = 2'd3;
  localparam logic [2:0] LastStep     = 3'd5;
  localparam logic [2:0] LastRowCurve = 3'd3;
  localparam logic [2:0] LastCurve    = 3'd4;

  // lerp sequence of one cubic curve on the working taps
  function automatic bbpe_op_e step_op(input logic [2:0] step);
    bbpe_op_e op;
    case (step)
      3'd0:    op = OP_SHIFT;
      3'd1:    op = OP_SHIFT;
      3'd2:    op = OP_END_L1;
      3'd3:    op = OP_SHIFT;
      3'd4:    op = OP_END_L2;
      default: op = OP_END_CURVE;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

/* design/bicubic_bezier_patch_eval.sv */
// top level of the bicubic bezier patch evaluator (de casteljau, one shared multiplier)
`default_nettype none
`include "bicubic_bezier_patch_eval_defines.svh"

// Holds a 4x4 grid of 3D control points, signed Q16.16, and evaluates the patch at (u, v).
// An item is taken at a rising edge with start high and busy low.
// A load item (operation_i = 0) writes point_x/y/z_i into slot point_index_i in that
// cycle, gives no result, and busy stays low.
// An evaluate item (operation_i = 1) raises busy while it fetches the first grid row from
// the point ram, then runs the lerps, then passes a drain state. The 90 lerps (four row
// curves and one column curve, six lerps each, for x, y and z) go through one
// subtract-multiply unit with a registered product; x, y and z are issued in turn so each
// lerp sees the result of the one before it. Later rows are fetched while a row computes.
// The result is shown on surf_x/y/z_o with result_valid_o high for exactly one cycle, the
// first cycle with busy low again; the receiver cannot stall.
// A new item may be started in that same cycle.
// Reset clears the sequencer; grid slots hold nothing defined until they are loaded.
module bicubic_bezier_patch_eval
  import bbpe_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               operation_i,
  input  wire logic        [3:0]  point_index_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  input  wire logic        [16:0] param_u_i,
  input  wire logic        [16:0] param_v_i,
  output logic                    result_valid_o,
  output logic signed      [31:0] surf_x_o,
  output logic signed      [31:0] surf_y_o,
  output logic signed      [31:0] surf_z_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = CW + TWidth + 2;

  typedef logic signed [CW-1:0] coord_t;

  bbpe_state_e state_q, state_d;

  logic [2:0] step_q, curve_q;
  logic [1:0] coord_q;
  logic       issue, init_banks;

  logic       fetch_start;
  logic [1:0] fetch_row_start;
  logic       fetch_busy_q, rd_vld_q;
  logic [1:0] fetch_col_q, fetch_row_q;

  logic [TWidth-1:0] u_q, v_q, t_sel;

  logic            ram_we;
  logic [3*CW-1:0] ram_wdata, ram_rdata;
  coord_t          rd_x, rd_y, rd_z;

  coord_t pf_x_q [4], pf_y_q [4], pf_z_q [4];
  coord_t pf_x_d [4], pf_y_d [4], pf_z_d [4];
  coord_t pf_sel [4];

  // three rotating banks of working taps and row results
  coord_t b0_w_q [4], b0_r_q [4], b1_w_q [4], b1_r_q [4], pd_w_q [4], pd_r_q [4];
  coord_t b0_w_d [4], b0_r_d [4], b1_w_d [4], b1_r_d [4], pd_w_d [4], pd_r_d [4];
  coord_t nw [4], nr [4];

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod_d, prod_q;
  coord_t               a_q, lerp_r;
  bbpe_op_e             op_q;
  logic [1:0]           cp_q;
  logic [2:0]           curve_p_q;

  logic   fin, valid_d, valid_q;
  coord_t surf_x_q, surf_y_q, surf_z_q;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // point ram: one slot holds x, y and z
  assign ram_we    = accept && (operation_i == OperLoad);
  assign ram_wdata = {CW'(point_x_i), CW'(point_y_i), CW'(point_z_i)};
  assign rd_x      = ram_rdata[3*CW-1:2*CW];
  assign rd_y      = ram_rdata[2*CW-1:CW];
  assign rd_z      = ram_rdata[CW-1:0];

  bbpe_ram #(
    .WIDTH(3 * CW),
    .DEPTH(16)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(point_index_i),
    .wdata_i(ram_wdata),
    .raddr_i({fetch_row_q, fetch_col_q}),
    .rdata_o(ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    fetch_start     = 1'b0;
    fetch_row_start = 2'd0;
    issue           = 1'b0;
    init_banks      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OperEval)) begin
          state_d     = ST_FILL;
          fetch_start = 1'b1;
        end
      end
      ST_FILL: begin
        // last beat of row zero lands this cycle
        if (rd_vld_q && !fetch_busy_q) begin
          init_banks = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if ((step_q == 3'd0) && (coord_q == 2'd0) && (curve_q < LastRowCurve)) begin
          fetch_start     = 1'b1;
          fetch_row_start = 2'(curve_q + 3'd1);
        end
        if ((curve_q == LastCurve) && (step_q == LastStep) && (coord_q == LastCoord)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 3'd0;
      coord_q <= 2'd0;
      curve_q <= 3'd0;
    end else if (init_banks) begin
      step_q  <= 3'd0;
      coord_q <= 2'd0;
      curve_q <= 3'd0;
    end else if (issue) begin
      if (coord_q == LastCoord) begin
        coord_q <= 2'd0;
        if (step_q == LastStep) begin
          step_q  <= 3'd0;
          curve_q <= curve_q + 3'd1;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end else begin
        coord_q <= coord_q + 2'd1;
      end
    end
  end

  // row fetch engine, four reads per row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_busy_q <= 1'b0;
      fetch_col_q  <= 2'd0;
      fetch_row_q  <= 2'd0;
      rd_vld_q     <= 1'b0;
    end else begin
      rd_vld_q <= fetch_busy_q;
      if (fetch_start) begin
        fetch_busy_q <= 1'b1;
        fetch_col_q  <= 2'd0;
        fetch_row_q  <= fetch_row_start;
      end else if (fetch_busy_q) begin
        fetch_col_q <= fetch_col_q + 2'd1;
        if (fetch_col_q == LastCol) begin
          fetch_busy_q <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    pf_x_d = pf_x_q;
    pf_y_d = pf_y_q;
    pf_z_d = pf_z_q;
    if (rd_vld_q) begin
      for (int i = 0; i < 3; i++) begin
        pf_x_d[i] = pf_x_q[i+1];
        pf_y_d[i] = pf_y_q[i+1];
        pf_z_d[i] = pf_z_q[i+1];
      end
      pf_x_d[3] = rd_x;
      pf_y_d[3] = rd_y;
      pf_z_d[3] = rd_z;
    end
  end

  // parameters, saturated at one
  always_ff @(posedge clk_i) begin
    if (accept && (operation_i == OperEval)) begin
      u_q <= (param_u_i > TOne) ? TOne : param_u_i;
      v_q <= (param_v_i > TOne) ? TOne : param_v_i;
    end
  end

  assign t_sel = (curve_q == LastCurve) ? v_q : u_q;

  // shared lerp unit: subtract and multiply, then shift and add
  assign diff   = DW'(b0_w_q[1]) - DW'(b0_w_q[0]);
  assign prod_d = PW'(diff) * PW'($signed({1'b0, t_sel}));
  assign lerp_r = a_q + CW'(prod_q >>> FracBits);

  always_ff @(posedge clk_i) begin
    a_q    <= b0_w_q[0];
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= OP_NOP;
      cp_q      <= 2'd0;
      curve_p_q <= 3'd0;
    end else begin
      op_q      <= issue ? step_op(step_q) : OP_NOP;
      cp_q      <= coord_q;
      curve_p_q <= curve_q;
    end
  end

  // write back into the bank that was issued last cycle
  always_comb begin
    case (cp_q)
      2'd0:    pf_sel = pf_x_q;
      2'd1:    pf_sel = pf_y_q;
      default: pf_sel = pf_z_q;
    endcase
  end

  always_comb begin
    nw = pd_w_q;
    nr = pd_r_q;
    case (op_q)
      OP_SHIFT: begin
        nw[0] = pd_w_q[1];
        nw[1] = pd_w_q[2];
        nw[2] = pd_w_q[3];
        nw[3] = lerp_r;
      end
      OP_END_L1: begin
        nw[0] = pd_w_q[2];
        nw[1] = pd_w_q[3];
        nw[2] = lerp_r;
      end
      OP_END_L2: begin
        nw[0] = pd_w_q[3];
        nw[1] = lerp_r;
      end
      OP_END_CURVE: begin
        nr[0] = pd_r_q[1];
        nr[1] = pd_r_q[2];
        nr[2] = pd_r_q[3];
        nr[3] = lerp_r;
        // next row from the prefetch, or the row results for the column curve
        if (curve_p_q == LastRowCurve) begin
          nw[0] = pd_r_q[1];
          nw[1] = pd_r_q[2];
          nw[2] = pd_r_q[3];
          nw[3] = lerp_r;
        end else begin
          nw = pf_sel;
        end
      end
      default: begin
        nw = pd_w_q;
      end
    endcase
  end

  always_comb begin
    b0_w_d = b0_w_q;
    b0_r_d = b0_r_q;
    b1_w_d = b1_w_q;
    b1_r_d = b1_r_q;
    pd_w_d = pd_w_q;
    pd_r_d = pd_r_q;
    if (init_banks) begin
      b0_w_d = pf_x_d;
      b1_w_d = pf_y_d;
      pd_w_d = pf_z_d;
    end else if ((state_q == ST_RUN) || (state_q == ST_DRAIN)) begin
      b0_w_d = b1_w_q;
      b0_r_d = b1_r_q;
      b1_w_d = nw;
      b1_r_d = nr;
      pd_w_d = b0_w_q;
      pd_r_d = b0_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pf_x_q <= pf_x_d;
    pf_y_q <= pf_y_d;
    pf_z_q <= pf_z_d;
    b0_w_q <= b0_w_d;
    b0_r_q <= b0_r_d;
    b1_w_q <= b1_w_d;
    b1_r_q <= b1_r_d;
    pd_w_q <= pd_w_d;
    pd_r_q <= pd_r_d;
  end

  // result capture, strobe once z is in
  assign fin     = (op_q == OP_END_CURVE) && (curve_p_q == LastCurve);
  assign valid_d = fin && (cp_q == LastCoord);

  always_ff @(posedge clk_i) begin
    if (fin) begin
      case (cp_q)
        2'd0:    surf_x_q <= lerp_r;
        2'd1:    surf_y_q <= lerp_r;
        default: surf_z_q <= lerp_r;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign result_valid_o = valid_q;
  assign surf_x_o       = 32'(surf_x_q);
  assign surf_y_o       = 32'(surf_y_q);
  assign surf_z_o       = 32'(surf_z_q);

  `BBPE_ASSERT_IMP(a_valid_when_idle, result_valid_o, !busy)
  `BBPE_ASSERT_NXT(a_eval_enters_fill, accept && (operation_i == OperEval), state_q == ST_FILL)
  `BBPE_ASSERT_IMP(a_fetch_in_eval, fetch_busy_q, (state_q == ST_FILL) || (state_q == ST_RUN))
  `BBPE_ASSERT_IMP(a_result_after_drain, result_valid_o, $past(state_q) == ST_DRAIN)

endmodule

`default_nettype wire

/* design/bbpe_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module bbpe_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
